// ===== rtl/core/mbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared types, constants and the crc byte step for the register slave.
// ----------------------------------------------------------------------------
package mbrs_pkg;

  // frame layout and protocol constants
  localparam int unsigned FrameLen      = 8;
  localparam logic [7:0]  FnRead        = 8'h03;
  localparam logic [7:0]  FnWrite       = 8'h06;
  localparam logic [7:0]  FnErrFlag     = 8'h80;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [7:0]  NodeAddrReset = 8'h02;

  // frame byte positions
  localparam logic [2:0] PosAddr   = 3'd0;
  localparam logic [2:0] PosFn     = 3'd1;
  localparam logic [2:0] PosRegHi  = 3'd3;
  localparam logic [2:0] PosRegLo  = 3'd4;
  localparam logic [2:0] PosQty    = 3'd5;
  localparam logic [2:0] PosCrcHi  = 3'd6;
  localparam logic [2:0] PosLast   = 3'd7;
  localparam logic [2:0] RdCrcPos  = 3'd5;
  localparam logic [2:0] RdLastPos = 3'd6;

  // controller states
  typedef enum logic [1:0] {
    ST_RECV,
    ST_EVAL,
    ST_SEND
  } state_e;

  // kind of response being sent
  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_ERR
  } kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic  rx_ready;
    logic  rx_take;
    logic  eval;
    logic  ram_we;
    logic  ram_re;
    logic  tx_init;
    logic  tx_load;
    kind_e kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_pos;
    logic frame_ok;
    logic idx_ok;
    logic fn_read;
    logic fn_write;
    logic out_free;
    logic tx_last;
  } sts_t;

  // one byte of the reflected crc-16
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mbrs_if.sv =====
// ----------------------------------------------------------------------------
// mbrs channel interfaces
// Valid/ready channels for received bytes, response bytes and configuration.
// ----------------------------------------------------------------------------

// received byte channel
interface mbrs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// response byte channel
interface mbrs_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

// node address write channel
interface mbrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_address;
  modport source (output valid, output node_address, input ready);
  modport sink   (input valid, input node_address, output ready);
endinterface

// ===== rtl/core/mbrs_ram.sv =====
// ----------------------------------------------------------------------------
// mbrs_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module mbrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mbrs_datapath.sv =====
// ----------------------------------------------------------------------------
// mbrs_datapath
// Frame store, crc units, holding register ram and the response output stage.
// ----------------------------------------------------------------------------
module mbrs_datapath #(
  parameter int unsigned NUM_REGS = 16,
  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbrs_pkg::cmd_t      cmd_i,
  output mbrs_pkg::sts_t      sts_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                tx_ready_i,
  output logic                tx_valid_o,
  output logic [7:0]          tx_byte_o,
  output logic                tx_last_o
);

  logic [7:0]          frame_q [mbrs_pkg::FrameLen];
  logic [2:0]          pos_q, pos_d;
  logic [15:0]         rx_crc_q, rx_crc_d;
  logic [7:0]          node_addr_q;
  logic [NUM_REGS-1:0] vld_q, vld_d;
  logic                rd_vld_q;
  logic [15:0]         rdata;
  logic [15:0]         reg_val;
  logic [IdxW-1:0]     idx;
  logic [2:0]          tx_cnt_q, tx_cnt_d;
  logic [15:0]         tx_crc_q, tx_crc_d;
  logic                tx_valid_q, tx_valid_d;
  logic [7:0]          tx_byte_q;
  logic                tx_last_q;
  logic [7:0]          tx_sel;
  logic [7:0]          fn_out;
  logic                sel_last;
  logic                out_free;

  assign idx = frame_q[mbrs_pkg::PosRegHi][IdxW-1:0];

  // frame store, written at the current position
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take) begin
      frame_q[pos_q] <= rx_byte_i;
    end
  end

  // byte position and running request crc
  always_comb begin
    pos_d    = pos_q;
    rx_crc_d = rx_crc_q;
    if (cmd_i.rx_take) begin
      pos_d = pos_q + 3'd1;
      if (pos_q < mbrs_pkg::PosCrcHi) begin
        rx_crc_d = mbrs_pkg::crc_feed(rx_crc_q, rx_byte_i);
      end
    end
    if (cmd_i.eval) begin
      rx_crc_d = mbrs_pkg::CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      rx_crc_q <= mbrs_pkg::CrcInit;
    end else begin
      pos_q    <= pos_d;
      rx_crc_q <= rx_crc_d;
    end
  end

  // node address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= mbrs_pkg::NodeAddrReset;
    end else if (cfg_we_i) begin
      node_addr_q <= cfg_data_i;
    end
  end

  // frame checks
  always_comb begin
    sts_o.last_pos = (pos_q == mbrs_pkg::PosLast);
    sts_o.frame_ok = ({frame_q[mbrs_pkg::PosCrcHi], frame_q[mbrs_pkg::PosLast]} == rx_crc_q)
                     && (frame_q[mbrs_pkg::PosAddr] == node_addr_q);
    sts_o.idx_ok   = ({1'b0, frame_q[mbrs_pkg::PosRegHi]} < 9'(NUM_REGS));
    sts_o.fn_read  = (frame_q[mbrs_pkg::PosFn] == mbrs_pkg::FnRead);
    sts_o.fn_write = (frame_q[mbrs_pkg::PosFn] == mbrs_pkg::FnWrite);
    sts_o.out_free = out_free;
    sts_o.tx_last  = sel_last;
  end

  // holding registers
  mbrs_ram #(
    .WIDTH (16),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx),
    .wdata_i ({frame_q[mbrs_pkg::PosRegLo], frame_q[mbrs_pkg::PosQty]}),
    .re_i    (cmd_i.ram_re),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  // written flags, unwritten registers read as zero
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.ram_we) begin
      vld_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (cmd_i.ram_re) begin
        rd_vld_q <= vld_q[idx];
      end
    end
  end

  assign reg_val = rd_vld_q ? rdata : 16'h0000;

  // response byte select
  always_comb begin
    fn_out = (cmd_i.kind == mbrs_pkg::KIND_ERR) ? (frame_q[mbrs_pkg::PosFn] + mbrs_pkg::FnErrFlag)
                                                : frame_q[mbrs_pkg::PosFn];
    tx_sel = frame_q[tx_cnt_q];
    if (cmd_i.kind == mbrs_pkg::KIND_READ) begin
      sel_last = (tx_cnt_q == mbrs_pkg::RdLastPos);
      case (tx_cnt_q)
        3'd0:    tx_sel = frame_q[mbrs_pkg::PosAddr];
        3'd1:    tx_sel = fn_out;
        3'd2:    tx_sel = {frame_q[mbrs_pkg::PosQty][6:0], 1'b0};
        3'd3:    tx_sel = reg_val[15:8];
        3'd4:    tx_sel = reg_val[7:0];
        3'd5:    tx_sel = tx_crc_q[15:8];
        default: tx_sel = tx_crc_q[7:0];
      endcase
    end else begin
      sel_last = (tx_cnt_q == mbrs_pkg::PosLast);
      if (tx_cnt_q == mbrs_pkg::PosFn) begin
        tx_sel = fn_out;
      end
    end
  end

  // response counter and crc over the first five bytes of the read reply
  always_comb begin
    tx_cnt_d = tx_cnt_q;
    tx_crc_d = tx_crc_q;
    if (cmd_i.tx_init) begin
      tx_cnt_d = 3'd0;
      tx_crc_d = mbrs_pkg::CrcInit;
    end else if (cmd_i.tx_load) begin
      tx_cnt_d = tx_cnt_q + 3'd1;
      if (tx_cnt_q < mbrs_pkg::RdCrcPos) begin
        tx_crc_d = mbrs_pkg::crc_feed(tx_crc_q, tx_sel);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q <= 3'd0;
    end else begin
      tx_cnt_q <= tx_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_crc_q <= tx_crc_d;
  end

  // output register, freed when the sink takes the transfer
  assign out_free = !tx_valid_q || tx_ready_i;

  always_comb begin
    tx_valid_d = tx_valid_q;
    if (cmd_i.tx_load) begin
      tx_valid_d = 1'b1;
    end else if (tx_ready_i) begin
      tx_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid_q <= 1'b0;
    end else begin
      tx_valid_q <= tx_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tx_load) begin
      tx_byte_q <= tx_sel;
      tx_last_q <= sel_last;
    end
  end

  assign tx_valid_o = tx_valid_q;
  assign tx_byte_o  = tx_byte_q;
  assign tx_last_o  = tx_last_q;

endmodule

// ===== rtl/core/mbrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbrs_ctrl
// Frame sequencer: collect bytes, evaluate the request, send the response.
// ----------------------------------------------------------------------------
module mbrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  input  mbrs_pkg::sts_t sts_i,
  output mbrs_pkg::cmd_t cmd_o
);

  mbrs_pkg::state_e state_q, state_d;
  mbrs_pkg::kind_e  kind_q, kind_d;
  logic             respond;

  assign respond = sts_i.frame_ok;

  // response kind decided at evaluation
  always_comb begin
    kind_d = kind_q;
    if (state_q == mbrs_pkg::ST_EVAL) begin
      if (!sts_i.idx_ok) begin
        kind_d = mbrs_pkg::KIND_ERR;
      end else if (sts_i.fn_read) begin
        kind_d = mbrs_pkg::KIND_READ;
      end else if (sts_i.fn_write) begin
        kind_d = mbrs_pkg::KIND_WRITE;
      end else begin
        kind_d = mbrs_pkg::KIND_ERR;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbrs_pkg::ST_RECV: begin
        if (rx_valid_i && sts_i.last_pos) begin
          state_d = mbrs_pkg::ST_EVAL;
        end
      end
      mbrs_pkg::ST_EVAL: begin
        state_d = respond ? mbrs_pkg::ST_SEND : mbrs_pkg::ST_RECV;
      end
      mbrs_pkg::ST_SEND: begin
        if (sts_i.out_free && sts_i.tx_last) begin
          state_d = mbrs_pkg::ST_RECV;
        end
      end
      default: state_d = mbrs_pkg::ST_RECV;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = kind_q;
    case (state_q)
      mbrs_pkg::ST_RECV: begin
        cmd_o.rx_ready = 1'b1;
        cmd_o.rx_take  = rx_valid_i;
      end
      mbrs_pkg::ST_EVAL: begin
        cmd_o.eval    = 1'b1;
        cmd_o.tx_init = 1'b1;
        cmd_o.ram_we  = respond && sts_i.idx_ok && sts_i.fn_write;
        cmd_o.ram_re  = respond && sts_i.idx_ok && sts_i.fn_read;
      end
      mbrs_pkg::ST_SEND: begin
        cmd_o.tx_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrs_pkg::ST_RECV;
      kind_q  <= mbrs_pkg::KIND_ERR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== rtl/core/modbus_rtu_register_slave.sv =====
// After the last request byte, ST_EVAL checks the frame and ST_SEND loads the response bytes.
// Throughput: one request byte per cycle while collecting, one evaluation per frame, then
// one response byte per cycle while the sink is ready (7 for a read, 8 for an echo or error).
// The response sequencer holds off new request bytes until the last response byte is loaded.
// Reset: control clears, node address returns to 2, holding registers read as zero until written.
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave
// Fixed 8-byte frame register slave with crc check, read and write functions.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave #(
  parameter int unsigned NUM_REGS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbrs_rx_if.sink    rx_i,
  mbrs_tx_if.source  tx_o,
  mbrs_cfg_if.sink   cfg_i
);

  mbrs_pkg::cmd_t cmd;
  mbrs_pkg::sts_t sts;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = cmd.rx_ready;

  // sequencer
  mbrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  mbrs_datapath #(
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rx_byte_i  (rx_i.rx_byte),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.node_address),
    .tx_ready_i (tx_o.ready),
    .tx_valid_o (tx_o.valid),
    .tx_byte_o  (tx_o.tx_byte),
    .tx_last_o  (tx_o.last_byte)
  );

`ifndef SYNTHESIS
  // the eighth request byte always leads to an evaluation cycle
  a_eval_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rx_take && sts.last_pos) |=> cmd.eval)
    else $error("no evaluation after last frame byte");

  // a register is never read and written in the same evaluation
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ram_we && cmd.ram_re))
    else $error("holding register read and write together");

  // loading the last response byte returns to collecting bytes
  a_last_to_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.tx_load && sts.tx_last) |=> rx_i.ready)
    else $error("not ready for requests after last response byte");

  // request collection and response loading never overlap
  a_rx_tx_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rx_take && cmd.tx_load))
    else $error("request transfer during response");
`endif

endmodule
